### rtl/core/kwsc_pkg.sv
// ----------------------------------------------------------------------------
// kwsc_pkg
// Types and constants of the keyword substitution cipher.
// ----------------------------------------------------------------------------
package kwsc_pkg;

  localparam int unsigned Letters  = 26;
  localparam int unsigned IdxWidth = 5;

  localparam logic [2:0] MODE_CLEAR    = 3'd0;
  localparam logic [2:0] MODE_KEYWORD  = 3'd1;
  localparam logic [2:0] MODE_COMPLETE = 3'd2;
  localparam logic [2:0] MODE_ENCRYPT  = 3'd3;
  localparam logic [2:0] MODE_DECRYPT  = 3'd4;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  typedef logic [IdxWidth-1:0] idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOOKUP
  } state_e;

endpackage

### rtl/core/kwsc_ram.sv
// ----------------------------------------------------------------------------
// kwsc_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module kwsc_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 26
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/keyword_substitution_cipher.sv
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// Keyword substitution alphabet builder with letter encrypt and decrypt.
// ----------------------------------------------------------------------------
// The forward and inverse alphabets live in two 26-entry RAMs with a
// registered read. A text transaction reads the table, then loads the
// output register, which holds the result while the output side stalls.
// To complete the alphabet, the fill sequencer visits one letter of A to Z
// per cycle and writes both RAMs for each unused one. Per-entry valid bits
// make a cleared or reset entry read as the identity, so no clearing pass
// through the RAMs is needed.
module keyword_substitution_cipher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       substituted_o
);

  import kwsc_pkg::*;

  state_e state_q, state_d;

  logic [Letters-1:0] used_q, used_d;
  logic [Letters-1:0] fwd_vld_q, fwd_vld_d;
  logic [Letters-1:0] inv_vld_q, inv_vld_d;
  idx_t fill_q, fill_d;
  idx_t walk_q, walk_d;
  logic complete_q, complete_d;

  // Text transaction held during the lookup.
  logic       dec_q;
  logic       hit_q;
  logic       lower_q;
  idx_t       idx_q;
  logic [7:0] byte_q;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_sub_q;

  logic in_acc;
  logic is_upper, is_lower, is_letter;
  logic [7:0] upper_off, lower_off;
  idx_t in_idx;

  logic fwd_we, inv_we;
  idx_t fwd_waddr, inv_waddr, fwd_wdata, inv_wdata;
  idx_t fwd_rdata, inv_rdata;
  idx_t map_raw, map_idx;
  logic out_free, load_out;
  logic place_kw, place_fill;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_upper  = (in_byte_i >= CHAR_UPPER_A) && (in_byte_i <= CHAR_UPPER_Z);
  assign is_lower  = (in_byte_i >= CHAR_LOWER_A) && (in_byte_i <= CHAR_LOWER_Z);
  assign is_letter = is_upper || is_lower;
  assign upper_off = in_byte_i - CHAR_UPPER_A;
  assign lower_off = in_byte_i - CHAR_LOWER_A;
  assign in_idx    = is_lower ? lower_off[IdxWidth-1:0] : upper_off[IdxWidth-1:0];

  assign place_kw = in_acc && (mode_i == MODE_KEYWORD) && !complete_q && is_letter
                    && !used_q[in_idx] && (fill_q < idx_t'(Letters));
  assign place_fill = (state_q == ST_FILL) && !used_q[walk_q]
                      && (fill_q < idx_t'(Letters));

  // Both placement sources write forward[fill] = letter and inverse[letter] = fill.
  always_comb begin
    fwd_we    = place_kw || place_fill;
    inv_we    = fwd_we;
    fwd_waddr = fill_q;
    inv_wdata = fill_q;
    fwd_wdata = place_fill ? walk_q : in_idx;
    inv_waddr = fwd_wdata;
  end

  kwsc_ram #(
    .Width(IdxWidth),
    .Depth(Letters)
  ) u_fwd_ram (
    .clk_i  (clk_i),
    .we_i   (fwd_we),
    .waddr_i(fwd_waddr),
    .wdata_i(fwd_wdata),
    .raddr_i(state_q == ST_LOOKUP ? idx_q : in_idx),
    .rdata_o(fwd_rdata)
  );

  kwsc_ram #(
    .Width(IdxWidth),
    .Depth(Letters)
  ) u_inv_ram (
    .clk_i  (clk_i),
    .we_i   (inv_we),
    .waddr_i(inv_waddr),
    .wdata_i(inv_wdata),
    .raddr_i(state_q == ST_LOOKUP ? idx_q : in_idx),
    .rdata_o(inv_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_i == MODE_COMPLETE && !complete_q) begin
            state_d = ST_FILL;
          end else if (mode_i == MODE_ENCRYPT || mode_i == MODE_DECRYPT) begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_FILL: begin
        if (walk_q == idx_t'(Letters - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == ST_LOOKUP) && out_free;

  // An entry not written since the last clear reads as the identity.
  always_comb begin
    if (dec_q) begin
      map_raw = inv_vld_q[idx_q] ? inv_rdata : idx_q;
    end else begin
      map_raw = fwd_vld_q[idx_q] ? fwd_rdata : idx_q;
    end
    map_idx = (map_raw >= idx_t'(Letters)) ? '0 : map_raw;
  end

  // Key state and output control.
  always_comb begin
    used_d      = used_q;
    fwd_vld_d   = fwd_vld_q;
    inv_vld_d   = inv_vld_q;
    fill_d      = fill_q;
    walk_d      = walk_q;
    complete_d  = complete_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end

    if (in_acc && mode_i == MODE_CLEAR) begin
      used_d     = '0;
      fwd_vld_d  = '0;
      inv_vld_d  = '0;
      fill_d     = '0;
      complete_d = 1'b0;
    end
    if (in_acc && mode_i == MODE_COMPLETE && !complete_q) begin
      walk_d = '0;
    end
    if (fwd_we) begin
      used_d[inv_waddr]    = 1'b1;
      inv_vld_d[inv_waddr] = 1'b1;
      fwd_vld_d[fwd_waddr] = 1'b1;
      fill_d               = fill_q + idx_t'(1);
    end
    if (state_q == ST_FILL) begin
      walk_d = walk_q + idx_t'(1);
      if (walk_q == idx_t'(Letters - 1)) begin
        complete_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      fwd_vld_q   <= '0;
      inv_vld_q   <= '0;
      fill_q      <= '0;
      walk_q      <= '0;
      complete_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      fwd_vld_q   <= fwd_vld_d;
      inv_vld_q   <= inv_vld_d;
      fill_q      <= fill_d;
      walk_q      <= walk_d;
      complete_q  <= complete_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dec_q   <= (mode_i == MODE_DECRYPT);
      hit_q   <= is_letter && complete_q;
      lower_q <= is_lower;
      idx_q   <= in_idx;
      byte_q  <= in_byte_i;
    end
    if (load_out) begin
      out_byte_q <= hit_q ? ((lower_q ? CHAR_LOWER_A : CHAR_UPPER_A)
                            + {{(8 - IdxWidth){1'b0}}, map_idx})
                          : byte_q;
      out_sub_q  <= hit_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign substituted_o = out_sub_q;

endmodule
